### rtl/md5_pkg.sv
// ----------------------------------------------------------------------------
// MD5 package
// Round constants, shift amounts and the controller/datapath command types.
// ----------------------------------------------------------------------------
package md5_pkg;

  localparam logic [31:0] IvA = 32'h67452301;
  localparam logic [31:0] IvB = 32'hefcdab89;
  localparam logic [31:0] IvC = 32'h98badcfe;
  localparam logic [31:0] IvD = 32'h10325476;

  localparam logic [7:0] PadByte = 8'h80;
  localparam int unsigned LenPos = 56;

  localparam logic [31:0] RoundConst [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] RotAmount [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       wr_byte;     // store a byte at wr_addr
    logic [5:0] wr_addr;
    logic [1:0] wr_sel;      // what to store
    logic       count_inc;   // add 8 to the bit count
    logic       round_start; // load working words from chain
    logic       round_en;    // perform one round
    logic [5:0] round_idx;
    logic       chain_add;   // fold working words into chain
    logic       finish;      // latch digest, reset chain and count
  } md5_cmd_t;

  localparam logic [1:0] SelData = 2'd0;
  localparam logic [1:0] SelPad  = 2'd1;
  localparam logic [1:0] SelZero = 2'd2;
  localparam logic [1:0] SelLen  = 2'd3;

endpackage

### rtl/md5_datapath.sv
// ----------------------------------------------------------------------------
// MD5 datapath
// Block buffer, bit count, chaining words and the one-round-per-cycle unit.
// ----------------------------------------------------------------------------
module md5_datapath
  import md5_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  md5_cmd_t     cmd_i,
  input  logic [7:0]   data_i,
  output logic [127:0] digest_o
);

  // The block buffer is kept as sixteen little-endian words with byte lanes.
  logic [31:0] buf_mem [16];
  logic [31:0] word_q;
  logic [63:0] count_q, count_d;
  logic [31:0] ch_q [4];
  logic [31:0] va_q, vb_q, vc_q, vd_q;
  logic [127:0] digest_q;
  logic [7:0]  wr_data;
  logic [3:0]  widx;
  logic [1:0]  grp;
  logic [31:0] fv, sum, rot;
  logic [4:0]  sh;

  assign count_d = count_q + 64'd8;

  always_comb begin
    case (cmd_i.wr_sel)
      SelData: wr_data = data_i;
      SelPad:  wr_data = PadByte;
      SelZero: wr_data = 8'h00;
      SelLen:  wr_data = count_q[{cmd_i.wr_addr[2:0], 3'b000} +: 8];
      default: wr_data = 8'h00;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_byte) begin
      buf_mem[cmd_i.wr_addr[5:2]][{cmd_i.wr_addr[1:0], 3'b000} +: 8] <= wr_data;
    end
  end

  // Message word index for the next round, decoded ahead of that round.
  always_comb begin
    grp = cmd_i.round_idx[5:4];
    case (grp)
      2'd0:    widx = cmd_i.round_idx[3:0];
      2'd1:    widx = 4'(5 * cmd_i.round_idx[3:0] + 1);
      2'd2:    widx = 4'(3 * cmd_i.round_idx[3:0] + 5);
      default: widx = 4'(7 * cmd_i.round_idx[3:0]);
    endcase
  end

  // One word is read per cycle and kept registered.
  always_ff @(posedge clk_i) begin
    word_q <= buf_mem[widx];
  end

  logic [5:0] rnd_q;
  always_ff @(posedge clk_i) rnd_q <= cmd_i.round_idx;

  always_comb begin
    case (rnd_q[5:4])
      2'd0:    fv = (vb_q & vc_q) | (~vb_q & vd_q);
      2'd1:    fv = (vb_q & vd_q) | (vc_q & ~vd_q);
      2'd2:    fv = vb_q ^ vc_q ^ vd_q;
      default: fv = vc_q ^ (vb_q | ~vd_q);
    endcase
    sum = va_q + fv + RoundConst[rnd_q] + word_q;
    sh  = RotAmount[{rnd_q[5:4], rnd_q[1:0]}];
    rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ch_q[0] <= IvA;
      ch_q[1] <= IvB;
      ch_q[2] <= IvC;
      ch_q[3] <= IvD;
    end else begin
      if (cmd_i.finish) begin
        count_q <= '0;
        ch_q[0] <= IvA;
        ch_q[1] <= IvB;
        ch_q[2] <= IvC;
        ch_q[3] <= IvD;
      end else begin
        if (cmd_i.count_inc) begin
          count_q <= count_d;
        end
        if (cmd_i.chain_add) begin
          ch_q[0] <= ch_q[0] + va_q;
          ch_q[1] <= ch_q[1] + vb_q;
          ch_q[2] <= ch_q[2] + vc_q;
          ch_q[3] <= ch_q[3] + vd_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.round_start) begin
      va_q <= ch_q[0];
      vb_q <= ch_q[1];
      vc_q <= ch_q[2];
      vd_q <= ch_q[3];
    end else if (cmd_i.round_en) begin
      va_q <= vd_q;
      vd_q <= vc_q;
      vc_q <= vb_q;
      vb_q <= vb_q + rot;
    end
    if (cmd_i.finish) begin
      digest_q <= {ch_q[3], ch_q[2], ch_q[1], ch_q[0]};
    end
  end

  assign digest_o = digest_q;

endmodule

### rtl/md5_ctrl.sv
// ----------------------------------------------------------------------------
// MD5 controller
// Sequences byte intake, padding, length insertion and compression rounds.
// ----------------------------------------------------------------------------
module md5_ctrl
  import md5_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     byte_valid_i,
  input  logic     last_i,
  input  logic     out_ready_i,
  output logic     out_valid_o,
  output md5_cmd_t cmd_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StPad   = 3'd1;
  localparam logic [2:0] StLen   = 3'd2;
  localparam logic [2:0] StRound = 3'd3;
  localparam logic [2:0] StFold  = 3'd4;
  localparam logic [2:0] StFin   = 3'd5;

  logic [2:0] state_q, state_d;
  logic [5:0] fill_q, fill_d;
  logic [6:0] rnd_q, rnd_d;    // one extra step for the read-ahead
  logic       final_q, final_d; // this compression closes the message
  logic       pad_q, pad_d;     // the pad byte still goes into the next block
  logic       len_q, len_d;     // a block of zeros and the length still follows
  logic       out_valid_q, out_valid_d;
  logic       accept;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    rnd_d       = rnd_q;
    final_d     = final_q;
    pad_d       = pad_q;
    len_d       = len_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.wr_addr = fill_q;
    cmd_o.round_idx = rnd_q[5:0];
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (byte_valid_i) begin
            cmd_o.wr_byte   = 1'b1;
            cmd_o.wr_sel    = SelData;
            cmd_o.count_inc = 1'b1;
            fill_d = fill_q + 6'd1;
          end
          if (byte_valid_i && fill_q == 6'd63) begin
            state_d = StRound;
            rnd_d   = '0;
            pad_d   = last_i;
            cmd_o.round_start = 1'b1;
          end else if (last_i) begin
            state_d = StPad;
          end
        end
      end
      StPad: begin
        cmd_o.wr_byte = 1'b1;
        cmd_o.wr_sel  = SelPad;
        fill_d = fill_q + 6'd1;
        state_d = StLen;
        pad_d   = 1'b0;
        final_d = (fill_q < 6'(LenPos));
        len_d   = (fill_q >= 6'(LenPos));
        if (fill_q == 6'd63) begin
          state_d = StRound;
          rnd_d   = '0;
          cmd_o.round_start = 1'b1;
        end
      end
      StLen: begin
        // Zeros up to byte 56, then the bit count; all zeros if not final.
        cmd_o.wr_byte = 1'b1;
        if (!final_q || fill_q < 6'(LenPos)) begin
          cmd_o.wr_sel = SelZero;
        end else begin
          cmd_o.wr_sel = SelLen;
        end
        fill_d = fill_q + 6'd1;
        if (fill_q == 6'd63) begin
          state_d = StRound;
          rnd_d   = '0;
          cmd_o.round_start = 1'b1;
        end
      end
      StRound: begin
        // Step 0 fetches the word for round 0; rounds run on steps 1..64.
        cmd_o.round_en  = (rnd_q != 7'd0);
        cmd_o.round_idx = 6'(rnd_q);
        rnd_d = rnd_q + 7'd1;
        if (rnd_q == 7'd64) begin
          state_d = StFold;
        end
      end
      StFold: begin
        cmd_o.chain_add = 1'b1;
        if (final_q) begin
          state_d = StFin;
        end else if (pad_q) begin
          state_d = StPad;
        end else if (len_q) begin
          state_d = StLen;
          final_d = 1'b1;
          len_d   = 1'b0;
        end else begin
          state_d = StIdle;
        end
      end
      StFin: begin
        // Wait until the previous digest has been transferred.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          fill_d  = '0;
          final_d = 1'b0;
          pad_d   = 1'b0;
          len_d   = 1'b0;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      fill_q      <= '0;
      rnd_q       <= '0;
      final_q     <= 1'b0;
      pad_q       <= 1'b0;
      len_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      rnd_q       <= rnd_d;
      final_q     <= final_d;
      pad_q       <= pad_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### rtl/md5_digest_engine.sv
// A byte that does not fill a block is stored in the idle state; one that fills a
// block starts a compression (word fetch, 64 rounds, fold).
// A closing item takes padding writes, one or two compressions and a finish
// step; a second digest waits only while the first is held.
// Bytes are accepted only in the idle state, not during padding or compression.
// Reset: asynchronous, active low; chaining words, count and fill index clear.
// ----------------------------------------------------------------------------
// MD5 digest engine
// Byte-stream MD5 with a controller and a round datapath.
// ----------------------------------------------------------------------------
module md5_digest_engine
  import md5_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,  // data_byte
  input  logic         s_axis_tuser,  // byte_valid
  input  logic         s_axis_tlast,  // last_byte
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata   // digest_a, digest_b, digest_c, digest_d
);

  md5_cmd_t cmd;

  md5_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .byte_valid_i (s_axis_tuser),
    .last_i       (s_axis_tlast),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .cmd_o        (cmd)
  );

  md5_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .data_i   (s_axis_tdata),
    .digest_o (m_axis_tdata)
  );

endmodule

### bench/tb_md5_digest_engine.sv
// ----------------------------------------------------------------------------
// MD5 digest engine testbench
// Streams messages byte by byte into the engine, predicts each digest with a
// behavioral MD5 and compares every digest word with the prediction.
// ----------------------------------------------------------------------------
class digest_scoreboard;
  logic [31:0] chain [4];
  logic [63:0] bit_count;
  logic [7:0]  block_buf [64];
  int unsigned fill_idx;
  logic [127:0] pending_q [$];
  int unsigned err_count;

  function new();
    err_count = 0;
    clear_state();
  endfunction

  function void clear_state();
    chain[0] = md5_pkg::IvA;
    chain[1] = md5_pkg::IvB;
    chain[2] = md5_pkg::IvC;
    chain[3] = md5_pkg::IvD;
    bit_count = '0;
    fill_idx = 0;
    for (int i = 0; i < 64; i++) block_buf[i] = '0;
  endfunction

  function logic [31:0] rotl(logic [31:0] v, int unsigned s);
    if (s == 0) return v;
    return (v << s) | (v >> (32 - s));
  endfunction

  function void compress();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, f, t;
    int unsigned g, k;
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    for (int r = 0; r < 16; r++)
      w[r] = {block_buf[4*r+3], block_buf[4*r+2], block_buf[4*r+1], block_buf[4*r]};
    for (int r = 0; r < 64; r++) begin
      g = r / 16;
      case (g)
        0: begin f = (b & c) | (~b & d); k = r; end
        1: begin f = (b & d) | (c & ~d); k = (5*r + 1) % 16; end
        2: begin f = b ^ c ^ d; k = (3*r + 5) % 16; end
        default: begin f = c ^ (b | ~d); k = (7*r) % 16; end
      endcase
      t = d;
      d = c;
      c = b;
      b = b + rotl(a + f + md5_pkg::RoundConst[r] + w[k],
                   md5_pkg::RotAmount[g*4 + r%4]);
      a = t;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
  endfunction

  function void note_byte(logic [7:0] data, logic valid, logic last);
    logic [63:0] len;
    if (valid) begin
      block_buf[fill_idx] = data;
      bit_count += 64'd8;
      fill_idx = (fill_idx + 1) % 64;
      if (fill_idx == 0) compress();
    end
    if (!last) return;
    len = bit_count;
    block_buf[fill_idx] = md5_pkg::PadByte;
    for (int i = fill_idx + 1; i < 64; i++) block_buf[i] = '0;
    if (fill_idx >= md5_pkg::LenPos) begin
      compress();
      for (int i = 0; i < 64; i++) block_buf[i] = '0;
    end
    for (int i = 0; i < 8; i++) block_buf[md5_pkg::LenPos + i] = len[8*i +: 8];
    compress();
    pending_q.push_back({chain[3], chain[2], chain[1], chain[0]});
    clear_state();
  endfunction

  function void check_digest(logic [127:0] got);
    logic [127:0] exp;
    if (pending_q.size() == 0) begin
      $display("%0t: unexpected digest %h", $time, got);
      err_count++;
      return;
    end
    exp = pending_q.pop_front();
    for (int i = 0; i < 4; i++)
      if (got[32*i +: 32] !== exp[32*i +: 32]) begin
        $display("%0t: digest word %0d expected %h actual %h", $time, i,
                 exp[32*i +: 32], got[32*i +: 32]);
        err_count++;
      end
  endfunction
endclass

module tb_md5_digest_engine;
  import md5_pkg::*;

  localparam int unsigned StallLimit = 20000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;

  digest_scoreboard sb = new();
  int unsigned send_idle_pct = 34;
  int unsigned recv_idle_pct = 73;
  bit          hold_recv = 1'b0;
  int unsigned quiet_cycles = 0;

  always #2 clk_i = ~clk_i;

  md5_digest_engine i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  // Receiver side: random backpressure, optionally held off completely.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_digest(m_axis_tdata);
    m_axis_tready <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // The valid line stays up between back-to-back transfers and drops only
  // while the sender idles.
  task automatic send_byte(logic [7:0] data, logic valid, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= valid;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_byte(data, valid, last);
  endtask

  // A well-formed message with random content, sprinkled with idle items.
  task automatic send_message(int unsigned len, bit close_empty);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(15) == 0) send_byte(8'($urandom), 1'b0, 1'b0);
      send_byte(8'($urandom), 1'b1, !close_empty && (i == len - 1));
    end
    if (close_empty || len == 0) send_byte(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (250) @(posedge clk_i);
  endtask

  task automatic random_phase(int unsigned n_msgs);
    for (int m = 0; m < n_msgs; m++) begin
      case ($urandom_range(9))
        0:       send_message(0, 1'b1);
        1, 2:    send_message($urandom_range(54, 66), 1'($urandom_range(1)));
        3:       send_message($urandom_range(110, 130), 1'($urandom_range(1)));
        default: send_message($urandom_range(1, 20), 1'($urandom_range(1)));
      endcase
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty message, idle items, extreme bytes, lengths around the
    // padding boundary.
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hff, 1'b0, 1'b1);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hff, 1'b1, 1'b1);
    send_byte(8'h61, 1'b1, 1'b0);
    send_byte(8'h62, 1'b1, 1'b0);
    send_byte(8'h63, 1'b1, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);
    send_message(55, 1'b0);
    send_message(56, 1'b0);
    send_message(64, 1'b1);
    drain();

    random_phase(9);
    drain();

    // Hold the receiver off while messages keep coming in.
    fork
      begin
        hold_recv = 1'b1;
        repeat (600) @(posedge clk_i);
        hold_recv = 1'b0;
      end
      random_phase(3);
    join
    drain();

    send_idle_pct = 73;
    recv_idle_pct = 34;
    random_phase(7);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(7);
    drain();

    if (sb.err_count == 0 && sb.pending_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

### sim.f
rtl/md5_pkg.sv
rtl/md5_datapath.sv
rtl/md5_ctrl.sv
rtl/md5_digest_engine.sv
bench/tb_md5_digest_engine.sv
